### hw/rtl/ise_pkg.sv
// Shared types and constants of the insertion sort engine.
`default_nettype none

package ise_pkg;

    // Number of cells in the chain, one stored value each
    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    // Controller states
    typedef enum logic {
        ST_COLLECT = 1'b0,
        ST_EMIT    = 1'b1
    } ctrl_state_t;

    // Contents of one cell as seen by its neighbours
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } cell_t;

    // Control group from the controller to the chain
    typedef struct packed {
        cell_op_t                  op;
        logic signed [VALUE_W-1:0] value;
    } chain_cmd_t;

    // Status group from the chain to the controller
    typedef struct packed {
        logic                      head_valid;
        logic signed [VALUE_W-1:0] head_value;
        logic                      second_valid;
        logic                      full;
    } chain_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ise_cell.sv
// One compare-and-shift cell of the sorting chain.
`default_nettype none

module ise_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ise_pkg::chain_cmd_t cmd,
    input  wire ise_pkg::cell_t     prev_cell,
    input  wire logic               prev_gt,
    input  wire ise_pkg::cell_t     next_cell,
    output ise_pkg::cell_t          cell_q,
    output logic                    gt
);
    import ise_pkg::*;

    logic                      valid_reg, valid_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      active;

    // Empty cells count as greater than any value
    assign gt     = !valid_reg || (cmd.value < value_reg);
    // Only filled cells and the first empty one take part in an insertion
    assign active = valid_reg || prev_cell.valid;

    assign cell_q.valid = valid_reg;
    assign cell_q.value = value_reg;

    // Choose the next contents from the broadcast operation
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (cmd.op)
            OP_INSERT: begin
                if (active && gt) begin
                    valid_next = 1'b1;
                    value_next = prev_gt ? prev_cell.value : cmd.value;
                end
            end
            OP_SHIFT: begin
                valid_next = next_cell.valid;
                value_next = next_cell.value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### hw/rtl/ise_chain.sv
// Row of sorting cells with neighbour links.
`default_nettype none

module ise_chain (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ise_pkg::chain_cmd_t cmd,
    output ise_pkg::chain_stat_t     stat
);
    import ise_pkg::*;

    cell_t cells [CAPACITY];
    logic  gts   [CAPACITY];
    cell_t below [CAPACITY];
    cell_t above [CAPACITY];
    logic  below_gt [CAPACITY];

    // Link each cell to its neighbours; the ends see fixed boundaries
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign below[i]    = '{valid: 1'b1, value: '0};
            assign below_gt[i] = 1'b0;
        end else begin : g_mid
            assign below[i]    = cells[i-1];
            assign below_gt[i] = gts[i-1];
        end
        if (i == CAPACITY - 1) begin : g_top
            assign above[i] = '{valid: 1'b0, value: '0};
        end else begin : g_low
            assign above[i] = cells[i+1];
        end

        ise_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_cell (below[i]),
            .prev_gt   (below_gt[i]),
            .next_cell (above[i]),
            .cell_q    (cells[i]),
            .gt        (gts[i])
        );
    end

    // Report the head of the chain and its fill state
    assign stat.head_valid   = cells[0].valid;
    assign stat.head_value   = cells[0].value;
    assign stat.second_valid = cells[1].valid;
    assign stat.full         = cells[CAPACITY-1].valid;

endmodule

`default_nettype wire

### hw/rtl/insertion_sort_engine.sv
// Top level of the insertion sort engine: stream ports and batch control.
//
//  Channel  Direction  Payload
//  s_       in         tdata[31:0] value, tlast last_item
//  m_       out        tdata[31:0] sorted_value, tlast last_out, tuser overflow
//
// While collecting, one value per cycle is inserted against all cells in parallel,
// or dropped with overflow set if the chain is full. After the last item the batch
// drains from the head cell, one value per cycle with m_tready high; s_tready is low.
// The first result is offered in the cycle after the last item is accepted.
// Reset (aresetn low, synchronous) empties the chain and clears overflow.
// Results come straight from the head cell register and hold under stall.
`default_nettype none

module insertion_sort_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,
    output logic             m_tuser    // [0] overflow
);
    import ise_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        overflow_reg, overflow_next;
    chain_cmd_t  cmd;
    chain_stat_t stat;
    logic        s_xfer, m_xfer;

    ise_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign s_tready = (state_reg == ST_COLLECT);
    assign m_tvalid = (state_reg == ST_EMIT) && stat.head_valid;
    assign m_tdata  = stat.head_value;
    assign m_tlast  = !stat.second_valid;
    assign m_tuser  = overflow_reg;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // Next state, overflow flag and chain operation
    always_comb begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        cmd.op        = OP_HOLD;
        cmd.value     = s_tdata;
        unique case (state_reg)
            ST_COLLECT: begin
                if (s_xfer) begin
                    if (stat.full) begin
                        overflow_next = 1'b1;
                    end else begin
                        cmd.op = OP_INSERT;
                    end
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (m_xfer) begin
                    cmd.op = OP_SHIFT;
                    if (m_tlast) begin
                        state_next    = ST_COLLECT;
                        overflow_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_COLLECT;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

`ifndef SYNTHESIS
    // Input and output never move a transaction in the same cycle
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_xfer && m_xfer))
        else $error("input and output transactions overlap");

    // A draining batch is never empty
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> m_tvalid)
        else $error("emit state with empty chain");

    // After the final result the chain is empty and input reopens
    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> (s_tready && !stat.head_valid && !m_tuser))
        else $error("chain not empty after final result");

    // A last item always leads into draining
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tlast) |=> (state_reg == ST_EMIT))
        else $error("last item did not start emission");
`endif

endmodule

`default_nettype wire
